@@ rtl/indexed_sequence_store_defines.svh @@
// Assertion macros used by the indexed sequence store datapath.
`ifndef INDEXED_SEQUENCE_STORE_DEFINES_SVH
`define INDEXED_SEQUENCE_STORE_DEFINES_SVH

`ifndef SYNTH
`define ISS_ASSERT_IMPL(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("%m: same-cycle check failed");
`define ISS_ASSERT_NEXT(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("%m: next-cycle check failed");
`else
`define ISS_ASSERT_IMPL(name, clk, rst, ante, cons)
`define ISS_ASSERT_NEXT(name, clk, rst, ante, cons)
`endif

`endif

@@ rtl/iss_pkg.sv @@
// Shared constants, codes and controller/datapath interface types.
package iss_pkg;

  localparam int CAPACITY = 64;
  localparam int ADDR_W   = $clog2(CAPACITY);
  localparam int CNT_W    = 7;
  localparam int VALUE_W  = 32;
  localparam int INDEX_W  = 8;
  localparam int KIND_W   = 3;
  localparam int STATUS_W = 2;

  typedef enum logic [KIND_W-1:0] {
    KIND_GET  = 3'd0,
    KIND_HEAD = 3'd1,
    KIND_TAIL = 3'd2,
    KIND_AT   = 3'd3,
    KIND_DEL  = 3'd4
  } kind_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_DONE      = 2'd0,
    ST_BAD_INDEX = 2'd1,
    ST_FULL      = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECIDE,
    S_GET_WAIT,
    S_INS_LOOP,
    S_INS_WR,
    S_DEL_LOOP,
    S_DEL_WR,
    S_RESULT
  } state_t;

  typedef struct packed {
    logic latch_op;
    logic decide;
    logic cap_get;
    logic rd_ins;
    logic wr_ins;
    logic put;
    logic rd_del;
    logic wr_del;
    logic del_done;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic get_ok;
    logic ins_ok;
    logic del_ok;
    logic ins_more;
    logic del_more;
    logic out_busy;
  } sts_t;

endpackage

@@ rtl/iss_ram.sv @@
// Generic simple dual-port RAM with registered read.
module iss_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/iss_ctrl.sv @@
// Operation sequencer: accepts a word, steps the shift loops, releases the result.
module iss_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  iss_pkg::sts_t sts,
  output iss_pkg::cmd_t cmd
);

  iss_pkg::state_t state;
  iss_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= iss_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      iss_pkg::S_IDLE: begin
        if (in_valid) begin
          state_next = iss_pkg::S_DECIDE;
        end
      end
      iss_pkg::S_DECIDE: begin
        if (sts.get_ok) begin
          state_next = iss_pkg::S_GET_WAIT;
        end else if (sts.ins_ok) begin
          state_next = iss_pkg::S_INS_LOOP;
        end else if (sts.del_ok) begin
          state_next = iss_pkg::S_DEL_LOOP;
        end else begin
          state_next = iss_pkg::S_RESULT;
        end
      end
      iss_pkg::S_GET_WAIT: state_next = iss_pkg::S_RESULT;
      iss_pkg::S_INS_LOOP: begin
        state_next = sts.ins_more ? iss_pkg::S_INS_WR : iss_pkg::S_RESULT;
      end
      iss_pkg::S_INS_WR: state_next = iss_pkg::S_INS_LOOP;
      iss_pkg::S_DEL_LOOP: begin
        state_next = sts.del_more ? iss_pkg::S_DEL_WR : iss_pkg::S_RESULT;
      end
      iss_pkg::S_DEL_WR: state_next = iss_pkg::S_DEL_LOOP;
      iss_pkg::S_RESULT: begin
        if (!sts.out_busy) begin
          state_next = iss_pkg::S_IDLE;
        end
      end
      default: state_next = iss_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    case (state)
      iss_pkg::S_IDLE: begin
        in_ready     = 1'b1;
        cmd.latch_op = in_valid;
      end
      iss_pkg::S_DECIDE:   cmd.decide  = 1'b1;
      iss_pkg::S_GET_WAIT: cmd.cap_get = 1'b1;
      iss_pkg::S_INS_LOOP: begin
        cmd.rd_ins = sts.ins_more;
        cmd.put    = !sts.ins_more;
      end
      iss_pkg::S_INS_WR: cmd.wr_ins = 1'b1;
      iss_pkg::S_DEL_LOOP: begin
        cmd.rd_del   = sts.del_more;
        cmd.del_done = !sts.del_more;
      end
      iss_pkg::S_DEL_WR: cmd.wr_del   = 1'b1;
      iss_pkg::S_RESULT: cmd.load_out = !sts.out_busy;
      default: cmd = '0;
    endcase
  end

endmodule

@@ rtl/iss_datapath.sv @@
// Operand registers, entry count, shift pointer, entry RAM and output register.
`include "indexed_sequence_store_defines.svh"

module iss_datapath (
  input  logic                            clk,
  input  logic                            rst,
  input  logic [iss_pkg::KIND_W-1:0]      in_kind,
  input  logic [iss_pkg::INDEX_W-1:0]     in_index,
  input  logic [iss_pkg::VALUE_W-1:0]     in_value,
  input  iss_pkg::cmd_t                   cmd,
  output iss_pkg::sts_t                   sts,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [iss_pkg::VALUE_W-1:0]     out_read_value,
  output logic [iss_pkg::STATUS_W-1:0]    out_status,
  output logic [iss_pkg::CNT_W-1:0]       out_entry_count
);

  logic [iss_pkg::KIND_W-1:0]  op_kind;
  logic [iss_pkg::INDEX_W-1:0] op_tgt;
  logic [iss_pkg::VALUE_W-1:0] op_value;
  logic [iss_pkg::CNT_W-1:0]   count;
  logic [iss_pkg::CNT_W-1:0]   ptr;
  logic [iss_pkg::VALUE_W-1:0] res_value;
  iss_pkg::status_t            res_status;

  logic [iss_pkg::INDEX_W-1:0] tgt_in;
  logic [iss_pkg::INDEX_W-1:0] count_ext;
  logic [iss_pkg::CNT_W-1:0]   ptr_dec;
  logic [iss_pkg::CNT_W-1:0]   ptr_inc;
  logic                        is_ins;
  logic                        tgt_ins_ok;
  logic                        tgt_in_range;
  logic                        full;

  logic                        ram_we;
  logic [iss_pkg::ADDR_W-1:0]  ram_waddr;
  logic [iss_pkg::VALUE_W-1:0] ram_wdata;
  logic [iss_pkg::ADDR_W-1:0]  ram_raddr;
  logic [iss_pkg::VALUE_W-1:0] ram_rdata;

  assign count_ext    = {1'b0, count};
  assign ptr_dec      = ptr - 7'd1;
  assign ptr_inc      = ptr + 7'd1;
  assign is_ins       = (op_kind == iss_pkg::KIND_HEAD) || (op_kind == iss_pkg::KIND_TAIL) ||
                        (op_kind == iss_pkg::KIND_AT);
  assign tgt_ins_ok   = op_tgt <= count_ext;
  assign tgt_in_range = op_tgt < count_ext;
  assign full         = count == 7'(iss_pkg::CAPACITY);

  always_comb begin
    case (in_kind)
      iss_pkg::KIND_HEAD: tgt_in = '0;
      iss_pkg::KIND_TAIL: tgt_in = count_ext;
      default:            tgt_in = in_index;
    endcase
  end

  assign sts.get_ok   = (op_kind == iss_pkg::KIND_GET) && tgt_in_range;
  assign sts.ins_ok   = is_ins && tgt_ins_ok && !full;
  assign sts.del_ok   = (op_kind == iss_pkg::KIND_DEL) && tgt_in_range;
  assign sts.ins_more = {1'b0, ptr} > op_tgt;
  assign sts.del_more = ptr_inc < count;
  assign sts.out_busy = out_valid && !out_ready;

  // insert shifts from the top down, delete from the gap up
  assign ram_raddr = cmd.rd_ins ? ptr_dec[iss_pkg::ADDR_W-1:0] :
                     cmd.rd_del ? ptr_inc[iss_pkg::ADDR_W-1:0] :
                                  op_tgt[iss_pkg::ADDR_W-1:0];
  assign ram_we    = cmd.wr_ins || cmd.wr_del || cmd.put;
  assign ram_waddr = cmd.put ? op_tgt[iss_pkg::ADDR_W-1:0] : ptr[iss_pkg::ADDR_W-1:0];
  assign ram_wdata = cmd.put ? op_value : ram_rdata;

  iss_ram #(
    .WIDTH(iss_pkg::VALUE_W),
    .DEPTH(iss_pkg::CAPACITY)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (cmd.latch_op) begin
      op_kind  <= in_kind;
      op_tgt   <= tgt_in;
      op_value <= in_value;
    end
    if (cmd.decide) begin
      ptr <= is_ins ? count : op_tgt[iss_pkg::CNT_W-1:0];
    end else if (cmd.wr_ins) begin
      ptr <= ptr_dec;
    end else if (cmd.wr_del) begin
      ptr <= ptr_inc;
    end
    if (cmd.decide) begin
      if ((op_kind == iss_pkg::KIND_GET) && !tgt_in_range) begin
        res_value <= '1;
      end else begin
        res_value <= '0;
      end
      if ((((op_kind == iss_pkg::KIND_GET) || (op_kind == iss_pkg::KIND_DEL)) &&
           !tgt_in_range) || (is_ins && !tgt_ins_ok)) begin
        res_status <= iss_pkg::ST_BAD_INDEX;
      end else if (is_ins && full) begin
        res_status <= iss_pkg::ST_FULL;
      end else begin
        res_status <= iss_pkg::ST_DONE;
      end
    end else if (cmd.cap_get) begin
      res_value <= ram_rdata;
    end
    if (cmd.load_out) begin
      out_read_value  <= res_value;
      out_status      <= res_status;
      out_entry_count <= count;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.put) begin
        count <= count + 7'd1;
      end else if (cmd.del_done) begin
        count <= count - 7'd1;
      end
      if (cmd.load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  `ISS_ASSERT_IMPL(a_count_cap, clk, rst, 1'b1, count <= 7'(iss_pkg::CAPACITY))
  `ISS_ASSERT_NEXT(a_put_inc, clk, rst, cmd.put, count == $past(count) + 7'd1)
  `ISS_ASSERT_IMPL(a_del_nonempty, clk, rst, cmd.del_done, count != '0)
  `ISS_ASSERT_IMPL(a_full_status, clk, rst, cmd.load_out && (res_status == iss_pkg::ST_FULL), full)

endmodule

@@ rtl/indexed_sequence_store.sv @@
// Top level of the indexed sequence store: sequencer, datapath and stream ports.
//
//  channel | dir | handshake          | payload
//  --------+-----+--------------------+---------------------------------------------
//  s_      | in  | s_tvalid/s_tready  | tuser kind; tdata index, value
//  m_      | out | m_tvalid/m_tready  | tuser status; tdata read_value, entry_count
//
// One word at a time. A valid get steps through decide, a RAM read wait and result;
// a rejected or unknown operation goes from decide straight to result. Insert and
// delete loop over the moved entries: each costs one RAM read and one write.
// rst is synchronous; it empties the store, entry contents are left as is.
// A result waiting on m_tready lets the next word run up to its result; the
// sequencer then waits and s_tready stays low until the output register frees.
module indexed_sequence_store (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,   // [7:0] index, [39:8] value
  input  logic [2:0]  s_tuser,   // [2:0] kind
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,   // [31:0] read_value, [38:32] entry_count, [39] zero
  output logic [1:0]  m_tuser    // [1:0] status
);

  iss_pkg::cmd_t cmd;
  iss_pkg::sts_t sts;

  logic [iss_pkg::VALUE_W-1:0] read_value;
  logic [iss_pkg::CNT_W-1:0]   entry_count;

  iss_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .in_valid(s_tvalid),
    .in_ready(s_tready),
    .sts     (sts),
    .cmd     (cmd)
  );

  iss_datapath u_datapath (
    .clk            (clk),
    .rst            (rst),
    .in_kind        (s_tuser),
    .in_index       (s_tdata[7:0]),
    .in_value       (s_tdata[39:8]),
    .cmd            (cmd),
    .sts            (sts),
    .out_valid      (m_tvalid),
    .out_ready      (m_tready),
    .out_read_value (read_value),
    .out_status     (m_tuser),
    .out_entry_count(entry_count)
  );

  assign m_tdata = {1'b0, entry_count, read_value};

endmodule

@@ dv/indexed_sequence_store_checker.sv @@
// Checker for the indexed sequence store: tracks the sequence and compares every result word.
`timescale 1ns / 1ps

module indexed_sequence_store_checker
  import iss_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [39:0] s_tdata,   // [7:0] index, [39:8] value
  input  logic [2:0]  s_tuser,   // [2:0] kind
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [39:0] m_tdata,   // [31:0] read_value, [38:32] entry_count, [39] zero
  input  logic [1:0]  m_tuser,   // [1:0] status
  output int          error_count,
  output int          pending_count,
  output int          stored_count
);

  typedef struct {
    logic [VALUE_W-1:0] read_value;
    status_t            status;
    logic [CNT_W-1:0]   entry_count;
  } op_result_t;

  logic [VALUE_W-1:0] stored_values[$];
  op_result_t         expected_results[$];
  int                 mismatches = 0;
  int                 outstanding = 0;
  int                 fill = 0;

  assign error_count   = mismatches;
  assign pending_count = outstanding;
  assign stored_count  = fill;

  function automatic status_t insert_value(int pos, logic [VALUE_W-1:0] val);
    if (pos > stored_values.size()) return ST_BAD_INDEX;
    if (stored_values.size() >= CAPACITY) return ST_FULL;
    stored_values.insert(pos, val);
    return ST_DONE;
  endfunction

  function automatic op_result_t apply_op(logic [KIND_W-1:0] kind, logic [INDEX_W-1:0] idx,
                                          logic [VALUE_W-1:0] val);
    op_result_t r;
    int         n;
    n = stored_values.size();
    r.read_value = '0;
    r.status     = ST_DONE;
    case (kind)
      KIND_GET: begin
        if (idx < n) begin
          r.read_value = stored_values[idx];
        end else begin
          r.read_value = '1;
          r.status     = ST_BAD_INDEX;
        end
      end
      KIND_HEAD: r.status = insert_value(0, val);
      KIND_TAIL: r.status = insert_value(n, val);
      KIND_AT:   r.status = insert_value(idx, val);
      KIND_DEL: begin
        if (idx < n) stored_values.delete(idx);
        else r.status = ST_BAD_INDEX;
      end
      default: ;
    endcase
    r.entry_count = CNT_W'(stored_values.size());
    return r;
  endfunction

  always @(posedge clk) begin
    op_result_t exp_r;
    if (!rst) begin
      // result first: a word accepted this edge cannot be answered at the same edge
      if (m_tvalid && m_tready) begin
        if (expected_results.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected result word: expected none, actual tdata=%h tuser=%0d",
                   $time, m_tdata, m_tuser);
        end else begin
          exp_r = expected_results.pop_front();
          if (m_tdata[31:0] !== exp_r.read_value) begin
            mismatches++;
            $display("%0t: read_value mismatch: expected %h actual %h",
                     $time, exp_r.read_value, m_tdata[31:0]);
          end
          if (m_tuser !== exp_r.status) begin
            mismatches++;
            $display("%0t: status mismatch: expected %0d actual %0d",
                     $time, exp_r.status, m_tuser);
          end
          if (m_tdata[38:32] !== exp_r.entry_count) begin
            mismatches++;
            $display("%0t: entry_count mismatch: expected %0d actual %0d",
                     $time, exp_r.entry_count, m_tdata[38:32]);
          end
          if (m_tdata[39] !== 1'b0) begin
            mismatches++;
            $display("%0t: tdata pad mismatch: expected 0 actual %b", $time, m_tdata[39]);
          end
        end
      end
      if (s_tvalid && s_tready)
        expected_results.push_back(apply_op(s_tuser, s_tdata[7:0], s_tdata[39:8]));
      outstanding = expected_results.size();
      fill        = stored_values.size();
    end
  end

endmodule

@@ dv/indexed_sequence_store_test.sv @@
// Testbench top for the indexed sequence store: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module indexed_sequence_store_test;
  import iss_pkg::*;

  localparam int          PHASE_ITEMS  = 230;
  localparam int          HOLD_CYCLES  = 400;
  localparam int          DRAIN_CYCLES = 300;
  localparam int          CYCLE_LIMIT  = 1000000;
  localparam int          KIND_MAX     = (1 << KIND_W) - 1;
  localparam int          INDEX_MAX    = (1 << INDEX_W) - 1;
  localparam logic [2:0]  KIND_UNUSED  = 3'd5;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [39:0] s_tdata = '0;   // [7:0] index, [39:8] value
  logic [2:0]  s_tuser = '0;   // [2:0] kind
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [39:0] m_tdata;        // [31:0] read_value, [38:32] entry_count, [39] zero
  logic [1:0]  m_tuser;        // [1:0] status

  int   error_count;
  int   pending_count;
  int   stored_count;
  int   tx_idle_pct = 0;
  int   rx_idle_pct = 0;
  logic long_hold = 1'b0;
  bit   hold_taken = 1'b0;
  bit   growing = 1'b1;

  indexed_sequence_store i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  indexed_sequence_store_checker i_checker (
    .clk           (clk),
    .rst           (rst),
    .s_tvalid      (s_tvalid),
    .s_tready      (s_tready),
    .s_tdata       (s_tdata),
    .s_tuser       (s_tuser),
    .m_tvalid      (m_tvalid),
    .m_tready      (m_tready),
    .m_tdata       (m_tdata),
    .m_tuser       (m_tuser),
    .error_count   (error_count),
    .pending_count (pending_count),
    .stored_count  (stored_count)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // receiver: random backpressure, plus one long hold-off
  initial begin
    forever begin
      @(posedge clk);
      if (long_hold && !hold_taken) begin
        hold_taken = 1'b1;
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      m_tready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("DONE: errors detected");
    $finish;
  end

  task automatic send_word(input logic [2:0] kind, input logic [7:0] idx,
                           input logic [31:0] val);
    while ($urandom_range(99) < tx_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= kind;
    s_tdata  <= {val, idx};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  // grow toward full, linger there, then shrink toward empty, and so on
  task automatic send_random();
    int         c;
    int         pick;
    logic [2:0] kind;
    logic [7:0] idx;
    c = stored_count;
    if (growing && c >= CAPACITY && $urandom_range(3) == 0) growing = 1'b0;
    else if (!growing && c == 0 && $urandom_range(2) == 0) growing = 1'b1;
    pick = $urandom_range(99);
    if (pick < 6) begin
      kind = 3'($urandom_range(KIND_MAX));
      idx  = 8'($urandom_range(INDEX_MAX));
    end else begin
      if (growing)
        kind = pick < 25 ? KIND_HEAD : pick < 45 ? KIND_TAIL : pick < 75 ? KIND_AT :
               pick < 88 ? KIND_GET : KIND_DEL;
      else
        kind = pick < 11 ? KIND_HEAD : pick < 15 ? KIND_TAIL : pick < 18 ? KIND_AT :
               pick < 35 ? KIND_GET : KIND_DEL;
      if ($urandom_range(9) == 0) idx = 8'($urandom_range(INDEX_MAX, c));
      else if (kind == KIND_AT) idx = 8'($urandom_range(c));
      else idx = (c == 0) ? 8'd0 : 8'($urandom_range(c - 1));
    end
    send_word(kind, idx, $urandom());
  endtask

  initial begin
    tx_idle_pct = 10;
    rx_idle_pct = 77;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // empty store: reads, deletes and inserts past the end all rejected
    send_word(KIND_GET,  8'd0,   32'h1234_5678);
    send_word(KIND_GET,  8'd255, 32'hFFFF_FFFF);
    send_word(KIND_DEL,  8'd0,   32'h0);
    send_word(KIND_AT,   8'd1,   32'h5555_5555);
    send_word(KIND_AT,   8'd255, 32'hAAAA_AAAA);
    // inserts of every kind, value extremes
    send_word(KIND_AT,   8'd0,   32'h0000_0000);
    send_word(KIND_HEAD, 8'd200, 32'h8000_0000);
    send_word(KIND_TAIL, 8'd77,  32'h7FFF_FFFF);
    send_word(KIND_AT,   8'd3,   32'hFFFF_FFFF);
    send_word(KIND_AT,   8'd1,   32'h0000_0001);
    send_word(KIND_AT,   8'd6,   32'hDEAD_BEEF);
    // reads at both ends and just past the end
    send_word(KIND_GET,  8'd0,   32'h0);
    send_word(KIND_GET,  8'd4,   32'h0);
    send_word(KIND_GET,  8'd5,   32'h0);
    send_word(KIND_GET,  8'd128, 32'h0);
    // deletes: middle, last, out of range
    send_word(KIND_DEL,  8'd2,   32'hFFFF_FFFF);
    send_word(KIND_DEL,  8'd3,   32'h0);
    send_word(KIND_DEL,  8'd4,   32'h0);
    send_word(KIND_DEL,  8'd255, 32'h0);
    // reserved kinds do nothing
    send_word(KIND_UNUSED,          8'd0,   32'hFFFF_FFFF);
    send_word(KIND_UNUSED + 3'd1,   8'd1,   32'h1);
    send_word(3'(KIND_MAX),         8'd255, $urandom());
    send_word(KIND_DEL,  8'd0,   32'h0);
    send_word(KIND_GET,  8'd0,   32'h0);

    for (int i = 0; i < PHASE_ITEMS; i++) send_random();
    tx_idle_pct = 77;
    rx_idle_pct = 10;
    for (int i = 0; i < PHASE_ITEMS; i++) send_random();
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    long_hold <= 1'b1;
    for (int i = 0; i < PHASE_ITEMS; i++) send_random();
    s_tvalid <= 1'b0;

    wait (pending_count == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0 && pending_count == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule
